// File: sv/ccio_pkg.sv
// Shared types and constants for the coin and credit I/O controller.
// Used by ccio_core and coin_credit_io_controller_top; no dependencies.
package ccio_pkg;

  // Command bytes.
  localparam logic [7:0] CmdNop    = 8'h10;
  localparam logic [7:0] CmdPoll   = 8'h71;
  localparam logic [7:0] CmdStatus = 8'hb1;
  localparam logic [7:0] CmdSwitch = 8'ha1;
  localparam logic [7:0] CmdCredit = 8'he1;
  localparam logic [7:0] CmdNmi    = 8'h61;

  // Interrupt answer codes.
  localparam logic [1:0] IntNone = 2'd0;
  localparam logic [1:0] IntNmi  = 2'd1;
  localparam logic [1:0] IntMask = 2'd2;

  localparam logic [6:0] CreditMax   = 7'd99;
  localparam int unsigned FireBit    = 4;
  localparam logic [7:0] SwitchReply = 8'h80;
  localparam logic [7:0] PollTail    = 8'hff;

  typedef struct packed {
    logic [6:0] credit_count;
    logic       switch_mode;
    logic       coin_seen;
    logic       start_one_seen;
    logic       start_two_seen;
    logic       fire_held;
    logic       nmi_pending;
  } state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] command;
    logic       coin_key;
    logic       start_one_key;
    logic       start_two_key;
    logic [7:0] player_buttons;
  } item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_first;
    logic [7:0] reply_second;
    logic [7:0] reply_third;
    logic       unknown_command;
    logic [1:0] interrupt_kind;
  } result_t;

  // Two BCD digits of a 7-bit value; tens by reciprocal multiply (exact for every 7-bit input).
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    begin
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(tens * 4'd10);
      to_bcd = 8'({tens, 4'b0000} + {1'b0, ones});
    end
  endfunction

endpackage

// File: sv/ccio_core.sv
// Next-state and reply logic for one bus access of the I/O controller.
// Purely combinational; depends on ccio_pkg.
module ccio_core (
  input  ccio_pkg::item_t   item_i,
  input  ccio_pkg::state_t  state_i,
  input  logic              int1_enable_i,
  output ccio_pkg::state_t  state_o,
  output ccio_pkg::result_t result_o
);

  logic [6:0] credit_a;
  logic [6:0] credit_b;
  logic [6:0] credit_c;
  logic [7:0] buttons;

  // Poll chain: coin, then start one, then start two, on the running count.
  always_comb begin
    credit_a = state_i.credit_count;
    if (item_i.coin_key && !state_i.coin_seen && (state_i.credit_count < ccio_pkg::CreditMax)) begin
      credit_a = state_i.credit_count + 7'd1;
    end
    credit_b = credit_a;
    if (item_i.start_one_key && !state_i.start_one_seen && (credit_a >= 7'd1)) begin
      credit_b = credit_a - 7'd1;
    end
    credit_c = credit_b;
    if (item_i.start_two_key && !state_i.start_two_seen && (credit_b >= 7'd2)) begin
      credit_c = credit_b - 7'd2;
    end
    buttons = item_i.player_buttons;
    if (!item_i.player_buttons[ccio_pkg::FireBit] && state_i.fire_held) begin
      buttons[ccio_pkg::FireBit] = 1'b1;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (item_i.func) begin
      if (state_i.nmi_pending) begin
        state_o.nmi_pending     = 1'b0;
        result_o.interrupt_kind = ccio_pkg::IntNmi;
      end else if (int1_enable_i) begin
        result_o.interrupt_kind = ccio_pkg::IntMask;
      end else begin
        result_o.interrupt_kind = ccio_pkg::IntNone;
      end
    end else begin
      case (item_i.command)
        ccio_pkg::CmdNop: begin
        end
        ccio_pkg::CmdPoll: begin
          state_o.credit_count   = credit_c;
          state_o.coin_seen      = item_i.coin_key;
          state_o.start_one_seen = item_i.start_one_key;
          state_o.start_two_seen = item_i.start_two_key;
          state_o.fire_held      = !item_i.player_buttons[ccio_pkg::FireBit];
          result_o.reply_valid   = 1'b1;
          result_o.reply_first   = state_i.switch_mode ? ccio_pkg::SwitchReply
                                                       : ccio_pkg::to_bcd(credit_c);
          result_o.reply_second  = buttons;
          result_o.reply_third   = ccio_pkg::PollTail;
        end
        ccio_pkg::CmdStatus: begin
          state_o.credit_count = '0;
          result_o.reply_valid = 1'b1;
        end
        ccio_pkg::CmdSwitch: begin
          state_o.switch_mode = 1'b1;
        end
        ccio_pkg::CmdCredit: begin
          state_o.switch_mode = 1'b0;
        end
        ccio_pkg::CmdNmi: begin
          state_o.nmi_pending = 1'b1;
        end
        default: begin
          result_o.unknown_command = 1'b1;
        end
      endcase
    end
  end

endmodule

// File: sv/coin_credit_io_controller_top.sv
// Top level of the coin and credit I/O controller.
// Depends on ccio_pkg and ccio_core.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bus access per transfer:
//   a command byte write (func_i = 0) or an interrupt poll (func_i = 1), with
//   the current switch levels and player port byte.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   access, in order: reply bytes and flags for a command, the interrupt
//   answer for a poll.
//   An access is held in an input register, then the core logic updates the
//   credit state and loads the result register.
//   Throughput is one access per cycle while the receiver does not stall; the result
//   register frees up in the same cycle it is taken, so the two stages flow with no bubbles.
//   When the receiver stalls, hold the result; the input register then holds
//   too and in_stall_o rises only while that stage is full and blocked.
//   Reset clears credits, mode, edge detectors, NMI pending, int1_enable and
//   both stage valids. Write cfg_we_i / cfg_wdata_i only while idle.
module coin_credit_io_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] command_i,
  input  logic       coin_key_i,
  input  logic       start_one_key_i,
  input  logic       start_two_key_i,
  input  logic [7:0] player_buttons_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       reply_valid_o,
  output logic [7:0] reply_first_o,
  output logic [7:0] reply_second_o,
  output logic [7:0] reply_third_o,
  output logic       unknown_command_o,
  output logic [1:0] interrupt_kind_o
);

  logic               int1_enable_q;
  logic               s1_valid_q;
  ccio_pkg::item_t    s1_item_q;
  logic               s2_valid_q;
  ccio_pkg::result_t  s2_result_q;
  ccio_pkg::state_t   state_q;
  ccio_pkg::state_t   state_d;
  ccio_pkg::result_t  result_d;
  logic               s2_ready;
  logic               s1_ready;
  logic               s1_advance;

  // The result register accepts when empty or being drained this cycle.
  assign s2_ready   = !s2_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && s2_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  ccio_core u_core (
    .item_i        (s1_item_q),
    .state_i       (state_q),
    .int1_enable_i (int1_enable_q),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int1_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      int1_enable_q <= cfg_wdata_i;
    end
  end

  // Input stage: capture a transfer whenever the stage is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_item_q.func           <= func_i;
      s1_item_q.command        <= command_i;
      s1_item_q.coin_key       <= coin_key_i;
      s1_item_q.start_one_key  <= start_one_key_i;
      s1_item_q.start_two_key  <= start_two_key_i;
      s1_item_q.player_buttons <= player_buttons_i;
    end
  end

  // Commit controller state only as the access moves to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_advance) begin
      state_q <= state_d;
    end
  end

  // Result stage: load on advance, drop valid once taken with nothing behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      s2_result_q <= result_d;
    end
  end

  assign out_valid_o       = s2_valid_q;
  assign reply_valid_o     = s2_result_q.reply_valid;
  assign reply_first_o     = s2_result_q.reply_first;
  assign reply_second_o    = s2_result_q.reply_second;
  assign reply_third_o     = s2_result_q.reply_third;
  assign unknown_command_o = s2_result_q.unknown_command;
  assign interrupt_kind_o  = s2_result_q.interrupt_kind;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for coin_credit_io_controller_top: commands, key edges, credits,
// fire masking and interrupt answers. Depends on ccio_pkg and the top-level RTL.
module tb;

  localparam int unsigned StallLimit = 5000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       func_i = 1'b0;
  logic [7:0] command_i = 8'h00;
  logic       coin_key_i = 1'b0;
  logic       start_one_key_i = 1'b0;
  logic       start_two_key_i = 1'b0;
  logic [7:0] player_buttons_i = 8'hff;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       reply_valid_o;
  logic [7:0] reply_first_o;
  logic [7:0] reply_second_o;
  logic [7:0] reply_third_o;
  logic       unknown_command_o;
  logic [1:0] interrupt_kind_o;

  coin_credit_io_controller_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .command_i        (command_i),
    .coin_key_i       (coin_key_i),
    .start_one_key_i  (start_one_key_i),
    .start_two_key_i  (start_two_key_i),
    .player_buttons_i (player_buttons_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reply_valid_o    (reply_valid_o),
    .reply_first_o    (reply_first_o),
    .reply_second_o   (reply_second_o),
    .reply_third_o    (reply_third_o),
    .unknown_command_o(unknown_command_o),
    .interrupt_kind_o (interrupt_kind_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the controller state and of the int1_enable register.
  ccio_pkg::state_t ctl_shadow = '0;
  logic   int1_shadow = 1'b0;

  // Replies predicted at input transfer, retired at output transfer, in order.
  ccio_pkg::result_t pending_replies[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_accesses = 0;
  int unsigned n_replies = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;

  // Switch levels that persist across random accesses, so edges stay meaningful.
  logic coin_lvl = 1'b0;
  logic s1_lvl = 1'b0;
  logic s2_lvl = 1'b0;
  logic fire_lvl = 1'b1;

  // Advance the shadow state by one bus access and return the reply it causes.
  function automatic ccio_pkg::result_t predict_reply(input ccio_pkg::item_t acc);
    ccio_pkg::result_t r;
    logic [7:0]        btn;
    r = '0;
    btn = acc.player_buttons;
    if (acc.func) begin
      // Pending NMI wins and is consumed; otherwise the maskable answer if enabled.
      if (ctl_shadow.nmi_pending) begin
        ctl_shadow.nmi_pending = 1'b0;
        r.interrupt_kind = ccio_pkg::IntNmi;
      end else if (int1_shadow) begin
        r.interrupt_kind = ccio_pkg::IntMask;
      end
    end else begin
      case (acc.command)
        ccio_pkg::CmdNop: ;
        ccio_pkg::CmdPoll: begin
          // Coin adds on its rising edge only, never past the ceiling.
          if (acc.coin_key) begin
            if (!ctl_shadow.coin_seen && ctl_shadow.credit_count < ccio_pkg::CreditMax)
              ctl_shadow.credit_count = ctl_shadow.credit_count + 7'd1;
          end
          ctl_shadow.coin_seen = acc.coin_key;
          // Starts subtract on their rising edge only when enough credits are held.
          if (acc.start_one_key) begin
            if (!ctl_shadow.start_one_seen && ctl_shadow.credit_count >= 7'd1)
              ctl_shadow.credit_count = ctl_shadow.credit_count - 7'd1;
          end
          ctl_shadow.start_one_seen = acc.start_one_key;
          if (acc.start_two_key) begin
            if (!ctl_shadow.start_two_seen && ctl_shadow.credit_count >= 7'd2)
              ctl_shadow.credit_count = ctl_shadow.credit_count - 7'd2;
          end
          ctl_shadow.start_two_seen = acc.start_two_key;
          // Fire is active low: report only the first sample of a press.
          if (!btn[ccio_pkg::FireBit]) begin
            if (ctl_shadow.fire_held) btn[ccio_pkg::FireBit] = 1'b1;
            else ctl_shadow.fire_held = 1'b1;
          end else begin
            ctl_shadow.fire_held = 1'b0;
          end
          r.reply_valid = 1'b1;
          r.reply_first = ctl_shadow.switch_mode ? ccio_pkg::SwitchReply :
              {4'(ctl_shadow.credit_count / 7'd10), 4'(ctl_shadow.credit_count % 7'd10)};
          r.reply_second = btn;
          r.reply_third = ccio_pkg::PollTail;
        end
        ccio_pkg::CmdStatus: begin
          ctl_shadow.credit_count = '0;
          r.reply_valid = 1'b1;
        end
        ccio_pkg::CmdSwitch: ctl_shadow.switch_mode = 1'b1;
        ccio_pkg::CmdCredit: ctl_shadow.switch_mode = 1'b0;
        ccio_pkg::CmdNmi:    ctl_shadow.nmi_pending = 1'b1;
        default:             r.unknown_command = 1'b1;
      endcase
    end
    return r;
  endfunction

  // Predict on every input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_replies.push_back(predict_reply({func_i, command_i, coin_key_i,
          start_one_key_i, start_two_key_i, player_buttons_i}));
      n_accesses++;
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Retire the oldest prediction on every output transfer.
  always @(posedge clk_i) begin
    ccio_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_replies++;
      if (pending_replies.size() == 0) begin
        $display("%0t ns: reply with nothing outstanding, expected none, got 0x%0h",
                 $time, {reply_valid_o, reply_first_o, reply_second_o, reply_third_o,
                 unknown_command_o, interrupt_kind_o});
        n_errors++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("reply_valid", 8'(want.reply_valid), 8'(reply_valid_o));
        compare_field("reply_first", want.reply_first, reply_first_o);
        compare_field("reply_second", want.reply_second, reply_second_o);
        compare_field("reply_third", want.reply_third, reply_third_o);
        compare_field("unknown_command", 8'(want.unknown_command), 8'(unknown_command_o));
        compare_field("interrupt_kind", 8'(want.interrupt_kind), 8'(interrupt_kind_o));
      end
    end
  end

  // Receiver side: stall at random at the phase's rate.
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t ns: timeout, no transfer in %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one bus access: idle at random, then hold it until the transfer.
  task automatic send_access(input ccio_pkg::item_t acc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= acc.func;
    command_i        <= acc.command;
    coin_key_i       <= acc.coin_key;
    start_one_key_i  <= acc.start_one_key;
    start_two_key_i  <= acc.start_two_key;
    player_buttons_i <= acc.player_buttons;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_cmd(input logic [7:0] cmd, input logic coin, input logic s1,
                          input logic s2, input logic [7:0] btn);
    send_access({1'b0, cmd, coin, s1, s2, btn});
  endtask

  task automatic send_irq_poll(input logic [7:0] junk);
    send_access({1'b1, junk, 1'b0, 1'b0, 1'b0, 8'hff});
  endtask

  // Drop valid and wait until every predicted reply has been retired.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_int1_enable(input logic value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    int1_shadow = value;
    cfg_we_i    <= 1'b0;
  endtask

  // Every command, unknown bytes, key edges, fire masking and the NMI handoff.
  task automatic test_command_set();
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdNop, 1'b1, 1'b1, 1'b1, 8'h00);
    send_cmd(8'h00, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(8'hff, 1'b1, 1'b1, 1'b1, 8'h00);
    send_irq_poll(ccio_pkg::CmdStatus);                    // command byte ignored on a poll
    send_cmd(ccio_pkg::CmdPoll, 1'b1, 1'b0, 1'b0, 8'hff);  // coin edge: 01
    send_cmd(ccio_pkg::CmdPoll, 1'b1, 1'b0, 1'b0, 8'hff);  // coin held: no add
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b1, 8'hff);  // start-2 short of credits
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b1, 1'b1, 8'hff);  // start-1 takes the last one
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'h00);  // fire reported
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'h00);  // fire masked while held
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hef);
    send_cmd(ccio_pkg::CmdSwitch, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b1, 1'b0, 1'b0, 8'hff);  // switch mode reply
    send_cmd(ccio_pkg::CmdCredit, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdStatus, 1'b1, 1'b1, 1'b1, 8'h5a);
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdNmi, 1'b0, 1'b0, 1'b0, 8'hff);
    send_irq_poll(8'h00);                                  // NMI answered and cleared
    send_irq_poll(8'hff);                                  // nothing left to answer
  endtask

  // Maskable answer with int1_enable set, and NMI taking priority over it.
  task automatic test_interrupt_answers();
    write_int1_enable(1'b1);
    send_irq_poll(8'h71);
    send_cmd(ccio_pkg::CmdNmi, 1'b0, 1'b0, 1'b0, 8'hff);
    send_irq_poll(8'h00);
    send_irq_poll(8'h00);
    write_int1_enable(1'b0);
    send_irq_poll(8'h61);
  endtask

  // Climb to the ceiling with coin presses, push past it, then spend and clear.
  task automatic test_credit_ceiling();
    idle_pct  = 31;
    stall_pct = 31;
    repeat (101) begin
      send_cmd(ccio_pkg::CmdPoll, 1'b1, 1'b0, 1'b0, 8'hff);
      send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    end
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b1, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b1, 1'b1, 1'b1, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdStatus, 1'b0, 1'b0, 1'b0, 8'hff);
    send_cmd(ccio_pkg::CmdPoll, 1'b0, 1'b0, 1'b0, 8'hff);
    wait_idle();
  endtask

  // Half of the accesses are poll commands with persistent switch levels; the rest mixed commands,
  // interrupt polls and random bytes.
  function automatic ccio_pkg::item_t random_access();
    ccio_pkg::item_t acc;
    int unsigned     pick;
    pick = $urandom_range(99);
    if ($urandom_range(2) == 0) coin_lvl = ~coin_lvl;
    if ($urandom_range(7) == 0) s1_lvl = ~s1_lvl;
    if ($urandom_range(7) == 0) s2_lvl = ~s2_lvl;
    if ($urandom_range(4) < 2) fire_lvl = ~fire_lvl;
    acc.func           = (pick < 12);
    acc.command        = 8'($urandom());
    acc.coin_key       = coin_lvl;
    acc.start_one_key  = s1_lvl;
    acc.start_two_key  = s2_lvl;
    acc.player_buttons = 8'($urandom());
    acc.player_buttons[ccio_pkg::FireBit] = fire_lvl;
    if (pick >= 12 && pick < 62) acc.command = ccio_pkg::CmdPoll;
    else if (pick >= 62 && pick < 67) acc.command = ccio_pkg::CmdNmi;
    else if (pick >= 67 && pick < 70) acc.command = ccio_pkg::CmdSwitch;
    else if (pick >= 70 && pick < 75) acc.command = ccio_pkg::CmdCredit;
    else if (pick >= 75 && pick < 77) acc.command = ccio_pkg::CmdStatus;
    else if (pick >= 77 && pick < 80) acc.command = ccio_pkg::CmdNop;
    return acc;
  endfunction

  // Four phases of random traffic with different idle and stall pressure.
  task automatic test_random_traffic();
    int unsigned phase_idle[4]  = '{0, 66, 0, 31};
    int unsigned phase_stall[4] = '{0, 0, 66, 31};
    for (int p = 0; p < 4; p++) begin
      write_int1_enable(p[0] ? 1'b0 : 1'b1);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (200) send_access(random_access());
      wait_idle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_command_set();
    test_interrupt_answers();
    test_credit_ceiling();
    test_random_traffic();

    // Let the pipeline settle, then report.
    idle_pct = 0;
    wait_idle();
    repeat (4) @(posedge clk_i);
    n_errors += pending_replies.size();
    $display("Run covered %0d bus accesses and %0d checked replies:", n_accesses, n_replies);
    $display("  all commands, credit ceiling, fire masking, both interrupt settings, 4 phases");
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ccio_pkg.sv
sv/ccio_core.sv
sv/coin_credit_io_controller_top.sv
bench/tb.sv
